@@ rtl/sfr_pkg.sv @@
// Shared types and constants for the sum-checked frame receiver.
`default_nettype none

package sfr_pkg;

   localparam int BYTE_W     = 8;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [BYTE_W-1:0] HEAD_RESET = 8'h02;

   // Word index of the head byte register (paddr[2]).
   localparam logic REG_HEAD_BYTE = 1'b0;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BAD_HEAD = 2'd1,
      STATUS_BAD_SUM  = 2'd2,
      STATUS_BAD_LEN  = 2'd3
   } status_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic [BYTE_W-1:0] position;
      logic              frame_end;
      status_type        status;
   } frame_res_type;

endpackage

`default_nettype wire

@@ rtl/sfr_csr.sv @@
// Configuration register block: head byte register behind the APB-style port.
`default_nettype none

module sfr_csr
   import sfr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready,
   output logic      [BYTE_W-1:0]     head_byte
);

   logic [BYTE_W-1:0] head_byte_ff;
   logic [BYTE_W-1:0] head_byte_in;
   logic              head_sel;

   assign head_sel = (paddr[2] == REG_HEAD_BYTE);

   always_comb begin
      head_byte_in = head_byte_ff;
      if (psel && penable && pwrite && head_sel) begin
         head_byte_in = pwdata[BYTE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_byte_ff <= HEAD_RESET;
      end else begin
         head_byte_ff <= head_byte_in;
      end
   end

   // Unused low address bits alias onto the word.
   always_comb begin
      prdata = '0;
      if (head_sel) begin
         prdata = {{(CSR_DATA_W-BYTE_W){1'b0}}, head_byte_ff};
      end
   end

   assign pready    = 1'b1;
   assign head_byte = head_byte_ff;

endmodule

`default_nettype wire

@@ rtl/sfr_framer.sv @@
// Frame tracking state and per-byte framing and check logic.
`default_nettype none

module sfr_framer
   import sfr_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire logic [BYTE_W-1:0] rx_byte,
   input  wire logic [BYTE_W-1:0] head_byte,
   output frame_res_type          res
);

   logic [BYTE_W-1:0] byte_index_ff, byte_index_in;
   logic [BYTE_W-1:0] length_ff, length_in;
   logic [BYTE_W-1:0] sum_ff, sum_in;
   logic              head_ok_ff, head_ok_in;

   logic              at_head;
   logic              at_len;
   logic [BYTE_W-1:0] len;
   logic              frame_end;
   status_type        status;

   assign at_head = (byte_index_ff == '0);
   assign at_len  = (byte_index_ff == BYTE_W'(1));
   assign len     = at_len ? rx_byte : length_ff;

   always_comb begin
      if (at_head) begin
         frame_end = 1'b0;
      end else if (at_len) begin
         frame_end = (rx_byte <= BYTE_W'(1));
      end else begin
         frame_end = (byte_index_ff >= len);
      end
   end

   // Bad length outranks bad head, which outranks bad sum.
   always_comb begin
      status = STATUS_OK;
      if (frame_end) begin
         if (len == '0) begin
            status = STATUS_BAD_LEN;
         end else if (!head_ok_ff) begin
            status = STATUS_BAD_HEAD;
         end else if (sum_ff != rx_byte) begin
            status = STATUS_BAD_SUM;
         end
      end
   end

   always_comb begin
      byte_index_in = byte_index_ff;
      length_in     = length_ff;
      sum_in        = sum_ff;
      head_ok_in    = head_ok_ff;
      if (step) begin
         if (at_head) begin
            head_ok_in = (rx_byte == head_byte);
         end
         if (at_len) begin
            length_in = rx_byte;
         end
         if (frame_end) begin
            byte_index_in = '0;
            sum_in        = '0;
         end else begin
            byte_index_in = byte_index_ff + BYTE_W'(1);
            sum_in        = sum_ff + rx_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff <= '0;
         length_ff     <= '0;
         sum_ff        <= '0;
         head_ok_ff    <= 1'b0;
      end else begin
         byte_index_ff <= byte_index_in;
         length_ff     <= length_in;
         sum_ff        <= sum_in;
         head_ok_ff    <= head_ok_in;
      end
   end

   assign res.out_byte  = rx_byte;
   assign res.position  = byte_index_ff;
   assign res.frame_end = frame_end;
   assign res.status    = status;

endmodule

`default_nettype wire

@@ rtl/sum_checked_frame_receiver.sv @@
// Top level of the sum-checked frame receiver: input register, framer, result register.
`default_nettype none

// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+----------------------------------------
// req_     | in        | req_valid/req_stall  | req_rx_byte
// rsp_     | out       | rsp_valid/rsp_stall  | rsp_out_byte, rsp_position,
//          |           |                      | rsp_frame_end, rsp_status
// csr      | in/out    | psel/penable/pready  | paddr, pwdata, prdata (head byte at 0)
//
// One beat per cycle sustained while the result side does not stall; an accepted byte
// passes through the input register, then the framer logic, into the result register.
// Reset is synchronous and clears the frame position, length, sum, head flag and both
// valid flags; the head byte register returns to 0x02.
// A stalled result holds the result register and, with it, the input register; the
// input side stalls only while both registers are full and the result is stalled.

module sum_checked_frame_receiver
   import sfr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // input channel
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [BYTE_W-1:0]     req_rx_byte,
   // result channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic      [BYTE_W-1:0]     rsp_out_byte,
   output logic      [BYTE_W-1:0]     rsp_position,
   output logic                       rsp_frame_end,
   output logic      [1:0]            rsp_status,
   // configuration port
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   logic [BYTE_W-1:0] head_byte;

   // Input register.
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff, in_byte_in;

   // Result register.
   logic              out_valid_ff, out_valid_in;
   frame_res_type     out_res_ff, out_res_in;

   logic              advance;
   logic              req_take;
   logic              step;
   frame_res_type     res;

   sfr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .head_byte (head_byte)
   );

   // The pipe moves whenever the result register is empty or being drained.
   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   // Frame state updates only when the buffered byte moves into the result register.
   assign step      = in_valid_ff && advance;

   sfr_framer u_framer (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .rx_byte   (in_byte_ff),
      .head_byte (head_byte),
      .res       (res)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_take) begin
         // Load a new beat; the old one leaves in this same cycle.
         in_valid_in = 1'b1;
         in_byte_in  = req_rx_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_res_in   = out_res_ff;
      if (advance) begin
         out_valid_in = in_valid_ff;
         if (in_valid_ff) begin
            out_res_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      out_res_ff <= out_res_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_byte  = out_res_ff.out_byte;
   assign rsp_position  = out_res_ff.position;
   assign rsp_frame_end = out_res_ff.frame_end;
   assign rsp_status    = out_res_ff.status;

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// Self-checking bench for the sum-checked frame receiver: directed frames, then random traffic.
module tb;
   import sfr_pkg::*;

   // Byte addresses on the configuration port: the head byte register, and the first word
   // past it, which holds no register and must swallow writes.
   localparam logic [CSR_ADDR_W-1:0] ADDR_HEAD  = {REG_HEAD_BYTE, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_SPARE = 3'd4;

   localparam int RANDOM_ITEMS = 1450;
   localparam int PHASES       = 6;
   localparam int HOLD_AT_BEAT = 400;   // result count at which the sink holds off for long
   localparam int HOLD_CYCLES  = 80;

   typedef enum bit {ROW_BYTE, ROW_WRITE} row_kind_type;

   // One line of the directed table: either a byte to send or a register write.
   typedef struct {
      row_kind_type          kind;
      logic [CSR_ADDR_W-1:0] addr;
      logic [BYTE_W-1:0]     value;
      bit                    typed;   // 'want' was typed in by hand
      frame_res_type         want;
   } stim_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [BYTE_W-1:0]     req_rx_byte;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [BYTE_W-1:0]     rsp_out_byte;
   logic [BYTE_W-1:0]     rsp_position;
   logic                  rsp_frame_end;
   logic [1:0]            rsp_status;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // Framer state as the bench sees it, plus the head byte it believes is programmed.
   logic [BYTE_W-1:0] head_cfg;
   logic [BYTE_W-1:0] frame_pos;
   logic [BYTE_W-1:0] frame_len;
   logic [BYTE_W-1:0] frame_sum;
   logic              head_seen;

   frame_res_type framed_q[$];   // framed beats still owed by the block, oldest first
   stim_row_type  rows[$];
   int            errors;
   int            items_sent;
   int            beats_checked;
   bit            src_burst;
   bit            snk_burst;

   sum_checked_frame_receiver dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_rx_byte   (req_rx_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_position  (rsp_position),
      .rsp_frame_end (rsp_frame_end),
      .rsp_status    (rsp_status),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop in case the block wedges or drops a beat.
   initial begin
      #2_000_000;
      $display("sum_checked_frame_receiver regression: fail");
      $finish;
   end

   task automatic note_mismatch(input string what, input logic [7:0] got,
                                input logic [7:0] want);
      $display("beat %0d: %s is %0h, expected %0h", beats_checked, what, got, want);
      errors++;
   endtask

   // Advance the framer by one byte and return the beat it must produce.
   function automatic frame_res_type frame_next(input logic [BYTE_W-1:0] b);
      frame_res_type     r;
      logic [BYTE_W-1:0] len;
      logic              closing;
      len        = frame_len;
      closing    = 1'b0;
      r.out_byte = b;
      r.position = frame_pos;
      r.status   = STATUS_OK;
      if (frame_pos == 8'd0) begin
         head_seen = (b == head_cfg);
      end else if (frame_pos == 8'd1) begin
         // The length byte: 0 and 1 both close the frame right here.
         len       = b;
         frame_len = b;
         closing   = (b <= 8'd1);
      end else begin
         closing = (frame_pos >= len);
      end
      if (closing) begin
         // Bad length outranks bad head, which outranks bad sum.
         if (len == 8'd0)
            r.status = STATUS_BAD_LEN;
         else if (!head_seen)
            r.status = STATUS_BAD_HEAD;
         else if (frame_sum != b)
            r.status = STATUS_BAD_SUM;
         frame_pos = 8'd0;
         frame_sum = 8'd0;
      end else begin
         frame_pos = frame_pos + 8'd1;
         frame_sum = frame_sum + b;
      end
      r.frame_end = closing;
      return r;
   endfunction

   function automatic stim_row_type byte_row(input logic [BYTE_W-1:0] b);
      stim_row_type r;
      r.kind  = ROW_BYTE;
      r.addr  = '0;
      r.value = b;
      r.typed = 1'b0;
      r.want  = '0;
      return r;
   endfunction

   function automatic stim_row_type checked_row(input logic [BYTE_W-1:0] b,
                                                input logic [BYTE_W-1:0] pos,
                                                input logic fin, input status_type st);
      stim_row_type r;
      r                = byte_row(b);
      r.typed          = 1'b1;
      r.want.out_byte  = b;
      r.want.position  = pos;
      r.want.frame_end = fin;
      r.want.status    = st;
      return r;
   endfunction

   function automatic stim_row_type write_row(input logic [CSR_ADDR_W-1:0] addr,
                                              input logic [BYTE_W-1:0] value);
      stim_row_type r;
      r       = byte_row(value);
      r.kind  = ROW_WRITE;
      r.addr  = addr;
      return r;
   endfunction

   // Offer one byte after a random gap, hold it until the block takes it, then log
   // the beat it owes us.
   task automatic send_byte(input logic [BYTE_W-1:0] b, input bit typed = 1'b0,
                            input frame_res_type want = '0);
      int            gap;
      frame_res_type predicted;
      gap = src_burst ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      // Keep the predictor in step even where the expectation is typed in.
      predicted = frame_next(b);
      framed_q.push_back(typed ? want : predicted);
      items_sent++;
      if (items_sent % 64 == 0)
         src_burst = ($urandom_range(0, 3) == 0);
   endtask

   // Drop valid and wait for every owed beat to come out.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (framed_q.size() != 0) @(posedge clock);
   endtask

   // Write a register while idle, then read the head byte back.
   task automatic write_head_reg(input logic [CSR_ADDR_W-1:0] addr,
                                 input logic [BYTE_W-1:0] value);
      logic [CSR_DATA_W-1:0] data;
      wait_idle();
      data       = $urandom();
      data[7:0]  = value;
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      // Only word 0 holds a register; anything else is ignored.
      if (addr[2] == REG_HEAD_BYTE)
         head_cfg = value;
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= ADDR_HEAD;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[7:0] !== head_cfg)
         note_mismatch("head_byte readback", prdata[7:0], head_cfg);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Send a frame of the given length. Corrupt the check byte unless good_sum, and
   // stop after 'cut' bytes to leave a broken frame behind.
   task automatic send_frame(input logic [BYTE_W-1:0] len, input logic [BYTE_W-1:0] head,
                             input bit good_sum, input int cut);
      logic [BYTE_W-1:0] acc;
      logic [BYTE_W-1:0] b;
      int                total;
      acc   = 8'd0;
      total = (len <= 8'd1) ? 2 : int'(len) + 1;
      for (int i = 0; i < total && i < cut; i++) begin
         if (i == 0)
            b = head;
         else if (i == 1)
            b = len;
         else if (i == total - 1)
            b = good_sum ? acc : 8'($urandom_range(0, 255));
         else
            b = 8'($urandom_range(0, 255));
         acc = acc + b;
         send_byte(b);
      end
   endtask

   // Result side: stall at random, check every beat against the oldest expectation.
   initial begin : result_sink
      int            gap;
      frame_res_type want;
      rsp_stall = 1'b0;
      forever begin
         // Hold off once for a long stretch so the block backs up into its input.
         if (beats_checked == HOLD_AT_BEAT)
            gap = HOLD_CYCLES;
         else
            gap = snk_burst ? 0 : $urandom_range(0, 10);
         if (gap > 0) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
            repeat (gap - 1) @(negedge clock);
            @(negedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (rsp_valid !== 1'b1);
         if (framed_q.size() == 0) begin
            note_mismatch("unexpected beat, out_byte", rsp_out_byte, 8'd0);
         end else begin
            want = framed_q.pop_front();
            if (rsp_out_byte !== want.out_byte)
               note_mismatch("out_byte", rsp_out_byte, want.out_byte);
            if (rsp_position !== want.position)
               note_mismatch("position", rsp_position, want.position);
            if (rsp_frame_end !== want.frame_end)
               note_mismatch("frame_end", {7'd0, rsp_frame_end}, {7'd0, want.frame_end});
            if (rsp_status !== want.status)
               note_mismatch("status", {6'd0, rsp_status}, {6'd0, want.status});
         end
         beats_checked++;
         if (beats_checked % 50 == 0)
            snk_burst = ($urandom_range(0, 3) == 0);
      end
   end

   initial begin : stimulus
      logic [BYTE_W-1:0] phase_head;
      logic [BYTE_W-1:0] len;
      int                phase_start;
      int                pick;
      int                lsel;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_rx_byte = '0;
      psel        = 1'b0;
      penable     = 1'b0;
      pwrite      = 1'b0;
      paddr       = '0;
      pwdata      = '0;
      head_cfg    = HEAD_RESET;
      frame_pos   = '0;
      frame_len   = '0;
      frame_sum   = '0;
      head_seen   = 1'b0;
      errors      = 0;
      items_sent  = 0;
      beats_checked = 0;
      src_burst   = 1'b0;
      snk_burst   = 1'b0;

      // Directed table. Head byte is 0x02 out of reset.
      // Well-formed frame, len 3: 02 03 10, check 0x15.
      rows.push_back(byte_row(8'h02));
      rows.push_back(byte_row(8'h03));
      rows.push_back(byte_row(8'h10));
      rows.push_back(checked_row(8'h15, 8'd3, 1'b1, STATUS_OK));
      // Zero length closes at the length byte.
      rows.push_back(byte_row(8'h02));
      rows.push_back(checked_row(8'h00, 8'd1, 1'b1, STATUS_BAD_LEN));
      // Length one: the length byte is the check, compared with the head's value.
      rows.push_back(byte_row(8'h02));
      rows.push_back(checked_row(8'h01, 8'd1, 1'b1, STATUS_BAD_SUM));
      // Wrong head with a correct sum.
      rows.push_back(byte_row(8'h05));
      rows.push_back(byte_row(8'h02));
      rows.push_back(checked_row(8'h07, 8'd2, 1'b1, STATUS_BAD_HEAD));
      // Right head, wrong sum.
      rows.push_back(byte_row(8'h02));
      rows.push_back(byte_row(8'h02));
      rows.push_back(checked_row(8'h00, 8'd2, 1'b1, STATUS_BAD_SUM));
      // Wrong head and zero length: length wins.
      rows.push_back(byte_row(8'h07));
      rows.push_back(checked_row(8'h00, 8'd1, 1'b1, STATUS_BAD_LEN));
      // Head 0xff: sum wraps, ff + 02 = 01.
      rows.push_back(write_row(ADDR_HEAD, 8'hff));
      rows.push_back(byte_row(8'hff));
      rows.push_back(byte_row(8'h02));
      rows.push_back(checked_row(8'h01, 8'd2, 1'b1, STATUS_OK));
      // Head 0x01, then a write past the last register that must not land.
      // Length one then passes: check byte 01 equals the head.
      rows.push_back(write_row(ADDR_HEAD, 8'h01));
      rows.push_back(write_row(ADDR_SPARE, 8'h55));
      rows.push_back(byte_row(8'h01));
      rows.push_back(checked_row(8'h01, 8'd1, 1'b1, STATUS_OK));
      // Head 0x00.
      rows.push_back(write_row(ADDR_HEAD, 8'h00));
      rows.push_back(byte_row(8'h00));
      rows.push_back(byte_row(8'h02));
      rows.push_back(checked_row(8'h02, 8'd2, 1'b1, STATUS_OK));

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         if (rows[i].kind == ROW_WRITE)
            write_head_reg(rows[i].addr, rows[i].value);
         else
            send_byte(rows[i].value, rows[i].typed, rows[i].want);
      end

      // Random phases, each under its own head byte; extremes first, reset value too.
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0:       phase_head = 8'hff;
            1:       phase_head = 8'h00;
            2:       phase_head = HEAD_RESET;
            5:       phase_head = 8'h01;
            default: phase_head = 8'($urandom_range(0, 255));
         endcase
         if (ph == 3)
            write_head_reg(ADDR_SPARE, 8'($urandom_range(0, 255)));
         write_head_reg(ADDR_HEAD, phase_head);
         phase_start = items_sent;
         // Longest frame, closing at position 255.
         if (ph == 1 || ph == 4)
            send_frame(8'hff, head_cfg, 1'b1, 1000);
         while (items_sent - phase_start < RANDOM_ITEMS / PHASES) begin
            pick = $urandom_range(0, 99);
            if (pick < 78) begin
               // Mostly well-formed frames with random content.
               lsel = $urandom_range(0, 99);
               if (lsel < 6)
                  len = 8'd0;
               else if (lsel < 12)
                  len = 8'd1;
               else if (lsel < 90)
                  len = 8'($urandom_range(2, 8));
               else
                  len = 8'($urandom_range(9, 40));
               send_frame(len,
                          ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : head_cfg,
                          $urandom_range(0, 6) != 0, 1000);
            end else if (pick < 90) begin
               // Broken frame: drop the tail, the next bytes run into it.
               send_frame(8'($urandom_range(3, 12)), head_cfg, 1'b1, $urandom_range(1, 3));
            end else begin
               repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)));
            end
         end
      end

      // Drain, then let the clock run on so that any stray beat can show.
      wait_idle();
      repeat (8) @(posedge clock);
      if (errors == 0)
         $display("sum_checked_frame_receiver regression: pass");
      else
         $display("sum_checked_frame_receiver regression: fail");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/sfr_pkg.sv
rtl/sfr_csr.sv
rtl/sfr_framer.sv
rtl/sum_checked_frame_receiver.sv
bench/tb.sv
